// ===== sv/cbm_pkg.sv =====
// Shared codes and constants for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

  // Largest bank counts the mapper supports
  localparam int MAX_ROM_BANKS = 512;
  localparam int MAX_RAM_BANKS = 16;

  typedef logic [1:0] ctrl_t;
  typedef logic [1:0] target_t;
  typedef logic [1:0] cfg_idx_t;

  // Controller kinds
  localparam ctrl_t CTRL_ROM_ONLY = 2'd0;
  localparam ctrl_t CTRL_MBC1     = 2'd1;
  localparam ctrl_t CTRL_MBC5     = 2'd2;

  // Result target codes
  localparam target_t TGT_NONE = 2'd0;
  localparam target_t TGT_ROM  = 2'd1;
  localparam target_t TGT_RAM  = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_CONTROLLER = 2'd0;
  localparam cfg_idx_t CFG_ROM_BANKS  = 2'd1;
  localparam cfg_idx_t CFG_RAM_BANKS  = 2'd2;

  // Bank register region select (address bits 14:13)
  localparam logic [1:0] REG_RAM_EN   = 2'd0;
  localparam logic [1:0] REG_ROM_LO   = 2'd1;
  localparam logic [1:0] REG_BANK_HI  = 2'd2;
  localparam logic [1:0] REG_MODE     = 2'd3;

  localparam logic [2:0] RAM_WINDOW   = 3'b101; // A000-BFFF in address bits 15:13
  localparam logic [7:0] RAM_EN_KEY   = 8'h0A;

  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

endpackage : cbm_pkg

`default_nettype wire

// ===== sv/cartridge_bank_mapper.sv =====
// Cartridge bank mapper: bus access to external ROM/RAM offset, MBC1/MBC5 bank registers.
// Each access is held in the input register, then in the result register.
// Throughput: one access per cycle while out_tready does not stall; the bank register update
//   and offset mapping complete in the same cycle an access moves from input to result register.
// Reset (rst_n low, synchronous): controller MBC1, 2 ROM banks, no RAM, ROM bank 1,
//   RAM bank 0, ROM banking mode, RAM disabled; both pipeline stages empty.
`default_nettype none

module cartridge_bank_mapper (
  input  wire                          clk,
  input  wire                          rst_n,
  // configuration write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  cbm_pkg::cfg_idx_t      cfg_index,
  input  wire  [cbm_pkg::CFG_DATA_W-1:0] cfg_data,
  // bus access stream
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [cbm_pkg::IN_DATA_W-1:0] in_tdata,  // [15:0] address, [23:16] write_data
  input  wire                          in_tuser,   // kind: 0 read, 1 write
  // mapped result stream
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [cbm_pkg::OUT_DATA_W-1:0] out_tdata, // [22:0] mem_offset, [23] ram_write,
                                                    // [31:24] store_data, [32] ram_enabled,
                                                    // [33] unmapped, [39:34] zero
  output cbm_pkg::target_t             out_tuser    // target: 0 none, 1 ROM, 2 RAM
);

  import cbm_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user issues writes only while the mapper is idle;
  // the block itself does not enforce this. The port is always ready.
  // ---------------------------------------------------------------------------
  ctrl_t      controller_r;
  logic [9:0] rom_banks_r;
  logic [4:0] ram_banks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      controller_r <= CTRL_MBC1;
      rom_banks_r  <= 10'd2;
      ram_banks_r  <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONTROLLER: controller_r <= cfg_data[1:0];
        CFG_ROM_BANKS:  rom_banks_r  <= cfg_data[9:0];
        CFG_RAM_BANKS:  ram_banks_r  <= cfg_data[4:0];
        default: ;  // index past the register list: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the accepted access; it moves into the
  // result register whenever that register is empty or being drained.
  // ---------------------------------------------------------------------------
  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        advance;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Bank state
  // ---------------------------------------------------------------------------
  logic [8:0] rom_bank_r, rom_bank_nxt;
  logic [3:0] ram_bank_r, ram_bank_nxt;
  logic       mode_r,     mode_nxt;     // 1: RAM banking mode (MBC1)
  logic       ram_en_r,   ram_en_nxt;

  // Clamp limits from the bank counts
  logic [8:0] rom_top;
  logic [4:0] ram_count;

  always_comb begin
    if (rom_banks_r < 10'd2) begin
      rom_top = 9'd1;
    end else if (rom_banks_r > 10'(MAX_ROM_BANKS)) begin
      rom_top = 9'(MAX_ROM_BANKS - 1);
    end else begin
      rom_top = 9'(rom_banks_r - 10'd1);
    end
    if (ram_banks_r > 5'(MAX_RAM_BANKS)) begin
      ram_count = 5'(MAX_RAM_BANKS);
    end else begin
      ram_count = ram_banks_r;
    end
  end

  function automatic logic [8:0] clamp_rom(input logic [8:0] b, input logic [8:0] top);
    return (b > top) ? top : b;
  endfunction

  function automatic logic [3:0] clamp_ram(input logic [3:0] b, input logic [4:0] n);
    logic [4:0] last;
    last = n - 5'd1;
    if (n == 5'd0) begin
      return 4'd0;
    end
    return ({1'b0, b} > last) ? last[3:0] : b;
  endfunction

  // ---------------------------------------------------------------------------
  // Address decode, register writes and offset mapping for the access in stage 1
  // ---------------------------------------------------------------------------
  target_t     tgt;
  logic [22:0] off;
  logic        wr;
  logic [7:0]  sd;
  logic        unm;

  always_comb begin
    logic [4:0] lo;
    lo           = s1_data_r[4:0];
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    mode_nxt     = mode_r;
    ram_en_nxt   = ram_en_r;
    tgt          = TGT_NONE;
    off          = '0;
    wr           = 1'b0;
    sd           = '0;
    unm          = 1'b0;

    priority if (s1_addr_r[15:13] == RAM_WINDOW) begin
      // cart RAM window: unmapped without RAM, silent while disabled
      if (ram_count == 5'd0) begin
        unm = 1'b1;
      end else if (ram_en_r) begin
        tgt = TGT_RAM;
        off = {6'd0, ram_bank_r, s1_addr_r[12:0]};
        if (s1_kind_r) begin
          wr = 1'b1;
          sd = s1_data_r;
        end
      end
    end else if (s1_addr_r[15]) begin
      unm = 1'b1;
    end else if (!s1_kind_r) begin
      // ROM read: bank 0 fixed below 4000, switchable bank above
      tgt = TGT_ROM;
      if (!s1_addr_r[14]) begin
        off = {7'd0, s1_addr_r};
      end else begin
        off = {rom_bank_r, s1_addr_r[13:0]};
      end
    end else if (controller_r == CTRL_MBC1) begin
      unique case (s1_addr_r[14:13])
        REG_RAM_EN: begin
          ram_en_nxt = (s1_data_r[3:0] == RAM_EN_KEY[3:0]);
        end
        REG_ROM_LO: begin
          if (lo == 5'd0) begin
            lo = 5'd1;
          end
          rom_bank_nxt = clamp_rom({rom_bank_r[8:5], lo}, rom_top);
        end
        REG_BANK_HI: begin
          if (!mode_r) begin
            rom_bank_nxt = clamp_rom({2'b00, s1_data_r[1:0], rom_bank_r[4:0]}, rom_top);
          end else begin
            ram_bank_nxt = clamp_ram({2'b00, s1_data_r[1:0]}, ram_count);
          end
        end
        REG_MODE: begin
          if (s1_data_r[0]) begin
            // RAM mode keeps only the low 5 bank bits, never bank 0
            if (rom_bank_r[4:0] == 5'd0) begin
              rom_bank_nxt = 9'd1;
            end else begin
              rom_bank_nxt = {4'd0, rom_bank_r[4:0]};
            end
            mode_nxt = 1'b1;
          end else begin
            ram_bank_nxt = 4'd0;
            mode_nxt     = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (controller_r == CTRL_MBC5) begin
      unique case (s1_addr_r[14:13])
        REG_RAM_EN: begin
          ram_en_nxt = (s1_data_r == RAM_EN_KEY);
        end
        REG_ROM_LO: begin
          // 2000-2FFF low bank byte, 3000-3FFF bank bit 8
          if (!s1_addr_r[12]) begin
            rom_bank_nxt = clamp_rom({rom_bank_r[8], s1_data_r}, rom_top);
          end else begin
            rom_bank_nxt = clamp_rom({s1_data_r[0], rom_bank_r[7:0]}, rom_top);
          end
        end
        REG_BANK_HI: begin
          ram_bank_nxt = clamp_ram(s1_data_r[3:0], ram_count);
        end
        REG_MODE: begin
          unm = 1'b1;
        end
        default: ;
      endcase
    end else begin
      // ROM only (or the unused controller code): no registers
      unm = 1'b1;
    end
  end

  logic fire;
  assign fire = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= 9'd1;
      ram_bank_r <= 4'd0;
      mode_r     <= 1'b0;
      ram_en_r   <= 1'b0;
    end else if (fire) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      mode_r     <= mode_nxt;
      ram_en_r   <= ram_en_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (advance) begin
      out_tvalid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tuser <= tgt;
      out_tdata <= {6'd0, unm, ram_en_nxt, sd, wr, off};
    end
  end

endmodule : cartridge_bank_mapper

`default_nettype wire

// ===== sv/cbm_checker.sv =====
// Port-level checks for the cartridge bank mapper, bound to the top level.
`default_nettype none

module cbm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire [1:0]  out_tuser
);

  import cbm_pkg::*;

  // a RAM store strobe only ever goes with a RAM target
  a_wr_is_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[23]) |-> (out_tuser == TGT_RAM))
    else $error("ram_write without RAM target");

  // no target means no offset and no store data
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == TGT_NONE) |-> (out_tdata[31:0] == 32'd0))
    else $error("offset or store data on an empty target");

  // an unmapped access never reaches memory
  a_unmapped_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33]) |-> (out_tuser == TGT_NONE))
    else $error("unmapped access with a target");

  // a RAM transaction needs RAM enabled
  a_ram_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == TGT_RAM) |-> out_tdata[32])
    else $error("RAM target while RAM disabled");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule : cbm_checker

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
